/* rtl/core/tdes_pkg.sv */
package tdes_pkg;

  localparam int RoundCount = 16;
  localparam int PassCount  = 3;
  localparam int StageCount = RoundCount * PassCount;

  typedef enum logic [2:0] {
    RegKeyOne    = 3'd0,
    RegKeyTwo    = 3'd1,
    RegKeyThree  = 3'd2,
    RegTriple    = 3'd3,
    RegDecrypt   = 3'd4
  } reg_idx_e;

  typedef logic [47:0] round_key_t;

  localparam byte unsigned IP_TAB [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam byte unsigned FP_TAB [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam byte unsigned E_TAB [48] = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  localparam byte unsigned P_TAB [32] = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
  localparam byte unsigned PC1_TAB [56] = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,60,52,44,36,
    63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,29,21,13,5,28,20,12,4};
  localparam byte unsigned PC2_TAB [48] = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  localparam byte unsigned ROT_TAB [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
  localparam logic [3:0] S_TAB [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,5,6,3,11}};

  function automatic logic [63:0] perm64(input logic [63:0] x, input byte unsigned t [64]);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) y[63-i] = x[64-int'(t[i])];
    return y;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] h, input round_key_t k);
    logic [47:0] x;
    logic [31:0] acc;
    logic [31:0] y;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) x[47-i] = h[32-int'(E_TAB[i])];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      six = x[47-6*i -: 6];
      acc[31-4*i -: 4] = S_TAB[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) y[31-i] = acc[32-int'(P_TAB[i])];
    return y;
  endfunction

  // PC1, rotate by the cumulative shift for round r, PC2
  function automatic round_key_t sched_key(input logic [63:0] key, input int r);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [55:0] m;
    round_key_t  k;
    for (int i = 0; i < 56; i++) cd[55-i] = key[64-int'(PC1_TAB[i])];
    c = cd[55:28];
    d = cd[27:0];
    for (int j = 0; j < 16; j++) begin
      if (j <= r) begin
        if (ROT_TAB[j] == 8'd1) begin
          c = {c[26:0], c[27]};
          d = {d[26:0], d[27]};
        end else begin
          c = {c[25:0], c[27:26]};
          d = {d[25:0], d[27:26]};
        end
      end
    end
    m = {c, d};
    for (int i = 0; i < 48; i++) k[47-i] = m[56-int'(PC2_TAB[i])];
    return k;
  endfunction

endpackage

/* rtl/core/tdes_keysched.sv */
module tdes_keysched import tdes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  wr_key_i,
  input  logic        wr_en_i,
  input  logic [63:0] wr_data_i,
  output round_key_t  rk_o [PassCount*RoundCount]
);
  // Round keys held in flops, indexed by key slot and round; reset gives all-zero-key schedule.
  round_key_t rk_q [PassCount*RoundCount];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PassCount; k++)
        for (int r = 0; r < RoundCount; r++)
          rk_q[k*RoundCount+r] <= sched_key(64'd0, r);
    end else if (wr_en_i) begin
      for (int k = 0; k < PassCount; k++)
        for (int r = 0; r < RoundCount; r++)
          if (wr_key_i == 2'(k)) rk_q[k*RoundCount+r] <= sched_key(wr_data_i, r);
    end
  end

  assign rk_o = rk_q;
endmodule

/* rtl/core/tdes_round.sv */
module tdes_round import tdes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        vld_i,
  input  logic [63:0] lr_i,
  input  round_key_t  key_i,
  output logic        vld_o,
  output logic [63:0] lr_o
);
  logic        vld_q;
  logic [63:0] lr_q;
  logic [63:0] lr_d;

  assign lr_d = {lr_i[31:0], lr_i[63:32] ^ feistel(lr_i[31:0], key_i)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) lr_q <= lr_d;
  end

  assign vld_o = vld_q;
  assign lr_o  = lr_q;
endmodule

/* rtl/core/des_tdes_block_cipher.sv */
// Pipeline: one register per DES round, three passes of sixteen rounds; single DES passes
// through the two outer passes as bypass.
// Throughput: one item per cycle; the whole pipeline holds while the output is stalled.
// Reset: asynchronous active low; clears valid bits, keys and mode bits, and loads the
// round keys of all-zero keys. Key writes rebuild the round keys from the written key.
module des_tdes_block_cipher import tdes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_block_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_block_o
);
  logic [63:0] key_q [PassCount];
  logic        triple_q, decrypt_q;
  logic        wr_en;
  logic [2:0]  reg_idx;
  round_key_t  rk [PassCount*RoundCount];
  logic        adv;
  logic        vld [StageCount+1];
  logic [63:0] lr  [StageCount+1];
  logic [63:0] lr_in [StageCount];
  round_key_t  key_sel [StageCount];

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PassCount; k++) key_q[k] <= '0;
      triple_q  <= 1'b0;
      decrypt_q <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegKeyOne:   key_q[0] <= pwdata;
        RegKeyTwo:   key_q[1] <= pwdata;
        RegKeyThree: key_q[2] <= pwdata;
        RegTriple:   triple_q <= pwdata[0];
        RegDecrypt:  decrypt_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegKeyOne:   prdata = key_q[0];
      RegKeyTwo:   prdata = key_q[1];
      RegKeyThree: prdata = key_q[2];
      RegTriple:   prdata = {63'd0, triple_q};
      RegDecrypt:  prdata = {63'd0, decrypt_q};
      default:     prdata = '0;
    endcase
  end

  tdes_keysched u_keysched (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_key_i  (reg_idx[1:0]),
    .wr_en_i   (wr_en && (reg_idx == RegKeyOne || reg_idx == RegKeyTwo
                         || reg_idx == RegKeyThree)),
    .wr_data_i (pwdata),
    .rk_o      (rk)
  );

  // Whole pipe holds on output stall.
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  assign vld[0] = in_valid_i;
  assign lr[0]  = data_block_i;

  // Per pass: IP at entry, FP plus half swap at exit. Pass p uses key slot and direction
  // from mode; single mode runs plain passes only at p=1, others pass data through.
  for (genvar s = 0; s < StageCount; s++) begin : g_stage
    localparam int P = s / RoundCount;
    localparam int N = s % RoundCount;
    logic        act;
    logic        inv;
    logic [1:0]  slot;
    logic [5:0]  kidx;
    logic [63:0] pre;
    logic [63:0] post;
    logic [63:0] fin;
    logic [63:0] byp_q;

    always_comb begin
      act = triple_q || (P == 1);
      if (!triple_q) begin
        slot = 2'd0;
        inv  = decrypt_q;
      end else if (!decrypt_q) begin
        slot = 2'(P);
        inv  = (P == 1);
      end else begin
        slot = 2'(2 - P);
        inv  = (P != 1);
      end
      kidx = 6'(int'(slot) * RoundCount + (inv ? RoundCount-1-N : N));
      key_sel[s] = rk[kidx];
      pre = (N == 0 && act) ? perm64(lr[s], IP_TAB) : lr[s];
      lr_in[s] = pre;
    end

    tdes_round u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .vld_i  (vld[s]),
      .lr_i   (lr_in[s]),
      .key_i  (key_sel[s]),
      .vld_o  (vld[s+1]),
      .lr_o   (post)
    );

    // Bypass pass in single mode: undo the round by keeping the incoming value.
    always_ff @(posedge clk_i) begin
      if (adv) byp_q <= lr[s];
    end

    always_comb begin
      if (!act) fin = byp_q;
      else if (N == RoundCount-1) fin = perm64({post[31:0], post[63:32]}, FP_TAB);
      else fin = post;
      lr[s+1] = fin;
    end
  end

  assign out_valid_o    = vld[StageCount];
  assign result_block_o = lr[StageCount];
endmodule

/* test/tb_des_tdes_block_cipher.sv */
`timescale 1ns / 100ps

module tb_des_tdes_block_cipher;
  import tdes_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 60;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] data_block_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] result_block_o;

  des_tdes_block_cipher uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .data_block_i, .out_valid_o, .out_stall_i, .result_block_o
  );

  // mirror of the block's registers and round keys
  logic [63:0] key_mirror [3];
  logic        triple_q;
  logic        decrypt_q;
  round_key_t  round_keys [3][16];

  logic [63:0] cipher_queue [$];
  int          fail_count;
  int          cycle_count;
  int          blocks_sent;
  int          blocks_checked;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cycles;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void build_round_keys(int slot, logic [63:0] key);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [55:0] m;
    for (int i = 0; i < 56; i++) cd[55-i] = key[64-int'(PC1_TAB[i])];
    c = cd[55:28];
    d = cd[27:0];
    for (int r = 0; r < 16; r++) begin
      for (int s = 0; s < int'(ROT_TAB[r]); s++) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      m = {c, d};
      for (int i = 0; i < 48; i++) round_keys[slot][r][47-i] = m[56-int'(PC2_TAB[i])];
    end
  endfunction

  function automatic logic [31:0] round_mix(logic [31:0] half, round_key_t rkey);
    logic [47:0] x;
    logic [31:0] acc;
    logic [31:0] y;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) x[47-i] = half[32-int'(E_TAB[i])];
    x = x ^ rkey;
    for (int i = 0; i < 8; i++) begin
      six = x[47-6*i -: 6];
      acc[31-4*i -: 4] = S_TAB[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) y[31-i] = acc[32-int'(P_TAB[i])];
    return y;
  endfunction

  function automatic logic [63:0] des_single(logic [63:0] blk, int slot, bit inverse);
    logic [63:0] x;
    logic [63:0] z;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] t;
    for (int i = 0; i < 64; i++) x[63-i] = blk[64-int'(IP_TAB[i])];
    l = x[63:32];
    r = x[31:0];
    for (int n = 0; n < RoundCount; n++) begin
      t = r;
      r = l ^ round_mix(r, round_keys[slot][inverse ? RoundCount - 1 - n : n]);
      l = t;
    end
    x = {r, l};
    for (int i = 0; i < 64; i++) z[63-i] = x[64-int'(FP_TAB[i])];
    return z;
  endfunction

  function automatic logic [63:0] cipher_block(logic [63:0] blk);
    if (!triple_q) return des_single(blk, 0, decrypt_q);
    if (!decrypt_q) return des_single(des_single(des_single(blk, 0, 0), 1, 1), 2, 0);
    return des_single(des_single(des_single(blk, 2, 1), 1, 0), 0, 1);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // cycle counter and watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("des_tdes_block_cipher regression: fail");
      $finish;
    end
  end

  // result side: random stall or a long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_req && hold_cycles == 0) begin
      hold_cycles <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= (hold_cycles > 1);
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // inputs only move at the rising edge, so the falling edge sees settled values
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cipher_queue.size() == 0) begin
        $error("unexpected result_block %h", result_block_o);
        fail_count++;
      end else begin
        if (result_block_o !== cipher_queue[0]) begin
          $error("result_block expected %h actual %h", cipher_queue[0], result_block_o);
          fail_count++;
        end
        void'(cipher_queue.pop_front());
        blocks_checked++;
      end
    end
  end

  task automatic reg_write(reg_idx_e idx, logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 6'(8 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx) inside
      RegKeyOne, RegKeyTwo, RegKeyThree: begin
        key_mirror[int'(idx)] = value;
        build_round_keys(int'(idx), value);
      end
      RegTriple:  triple_q = value[0];
      RegDecrypt: decrypt_q = value[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (cipher_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_config(logic [63:0] k1, logic [63:0] k2, logic [63:0] k3,
                            bit triple, bit decrypt);
    wait_drained();
    reg_write(RegKeyOne, k1);
    reg_write(RegKeyTwo, k2);
    reg_write(RegKeyThree, k3);
    reg_write(RegTriple, {63'(~0), triple});
    reg_write(RegDecrypt, {63'(0), decrypt});
    @(posedge clk_i);
  endtask

  // called right after a rising edge; leaves valid high unless a gap follows
  task automatic send_block(logic [63:0] blk);
    bit taken;
    in_valid_i   <= 1'b1;
    data_block_i <= blk;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    cipher_queue.push_back(cipher_block(blk));
    blocks_sent++;
    // idle cycle by cycle so the idle share matches the percentage
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic test_directed();
    logic [63:0] edge_blocks [6];
    edge_blocks = '{64'h0, '1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                    64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001};
    // reset keys, single encrypt
    foreach (edge_blocks[i]) send_block(edge_blocks[i]);
    set_config(64'h1334_5779_9BBC_DFF1, 0, 0, 0, 0);
    send_block(64'h0123_4567_89AB_CDEF);
    send_block('1);
    set_config(64'h1334_5779_9BBC_DFF1, 0, 0, 0, 1);
    send_block(64'h85E8_1354_0F0A_B405);
    send_block(64'h0);
    set_config(64'h0123_4567_89AB_CDEF, 64'h2345_6789_ABCD_EF01,
               64'h4567_89AB_CDEF_0123, 1, 0);
    foreach (edge_blocks[i]) send_block(edge_blocks[i]);
    set_config('1, 64'h0, '1, 1, 1);
    send_block(64'h0);
    send_block('1);
    // address past the register list is dropped
    wait_drained();
    reg_write(reg_idx_e'(3'd5), '1);
    @(posedge clk_i);
    send_block(64'h0123_4567_89AB_CDEF);
  endtask

  task automatic test_random(int count, bit pressure);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(5))
          0: set_config(64'h0, 64'h0, 64'h0, 1'($urandom), 1'($urandom));
          1: set_config('1, '1, '1, 1'($urandom), 1'($urandom));
          default: set_config(rand64(), rand64(), rand64(), 1'($urandom), 1'($urandom));
        endcase
      end
      if (pressure && n == count / 2) hold_req = 1'b1;
      if (pressure && n == count / 2 + 100) hold_req = 1'b0;
      case ($urandom_range(9))
        0: send_block(64'h0);
        1: send_block('1);
        default: send_block(rand64());
      endcase
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    data_block_i = '0;
    fail_count = 0;
    cycle_count = 0;
    blocks_sent = 0;
    blocks_checked = 0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    triple_q = 1'b0;
    decrypt_q = 1'b0;
    for (int k = 0; k < 3; k++) begin
      key_mirror[k] = '0;
      build_round_keys(k, '0);
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    send_idle_pct = 8;
    recv_idle_pct = 50;
    test_random(300, 0);
    send_idle_pct = 50;
    recv_idle_pct = 8;
    test_random(300, 0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(300, 1);
    wait_drained();

    $display("Covered %0d blocks (%0d checked) over single and triple DES,", blocks_sent,
             blocks_checked);
    $display("encrypt and decrypt, edge and random keys, with stalls and a long hold-off.");
    if (fail_count == 0) begin
      $display("des_tdes_block_cipher regression: pass");
    end else begin
      $display("des_tdes_block_cipher regression: fail");
    end
    $finish;
  end

endmodule
